[src/qrs_pkg.sv]
package qrs_pkg;

    // coefficient and root formats
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int ROOT_W    = 48;

    // discriminant: unsigned magnitude and signed working width
    localparam int DISC_W = 2 * COEF_W + 1;
    localparam int DSGN_W = DISC_W + 1;

    // square root of d * 2^(2*FRAC_BITS)
    localparam int SQ_W  = (DISC_W + 1) / 2 + FRAC_BITS;
    localparam int RAD_W = 2 * SQ_W;

    // divider: denominator 2|a|, numerator magnitude
    localparam int DEN_W = COEF_W + 1;
    localparam int MAG_A = COEF_W - 1 + FRAC_BITS;
    localparam int MAG_W = ((MAG_A > SQ_W) ? MAG_A : SQ_W) + 1;
    localparam int NUM_W = MAG_W + 1;

    // signed quotient and clamp widths
    localparam int RES_W   = MAG_W + 1;
    localparam int CLAMP_W = (RES_W > ROOT_W) ? RES_W : ROOT_W;

    // cycles from accepted transaction to the edge that takes its result
    localparam int LATENCY = SQ_W + MAG_W + 4;

    typedef enum logic [1:0] {
        KIND_TWO     = 2'd0,
        KIND_REPEAT  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_DEGEN   = 2'd3
    } root_kind_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } coef_in_t;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root_plus;
        logic signed [ROOT_W-1:0] root_minus;
        root_kind_t               root_kind;
    } root_out_t;

    // travels alongside the square root
    typedef struct packed {
        root_kind_t             kind;
        logic                   a_neg;
        logic signed [COEF_W:0] t;
        logic [DEN_W-1:0]       den;
    } sq_side_t;

    // travels alongside the divider
    typedef struct packed {
        root_kind_t kind;
        logic       a_neg;
        logic       neg_p;
        logic       neg_m;
        logic       exact;
    } div_side_t;

    // saturate a wide signed value to the root width
    function automatic logic signed [ROOT_W-1:0] sat_root(logic signed [CLAMP_W-1:0] v);
        logic signed [CLAMP_W-1:0] hi;
        logic signed [CLAMP_W-1:0] lo;
        logic signed [ROOT_W-1:0]  r;
        hi = {{(CLAMP_W - ROOT_W + 1){1'b0}}, {(ROOT_W - 1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            r = hi[ROOT_W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[ROOT_W-1:0];
        end
        else
        begin
            r = v[ROOT_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/qrs_sqrt.sv]
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] rad,
    input  sq_side_t         in_side,
    output logic             out_valid,
    output logic [SQ_W-1:0]  root,
    output logic             exact,
    output sq_side_t         out_side
);

    // one result bit per stage, most significant first
    logic [SQ_W-1:0]  v_reg;
    logic [SQ_W-1:0]  v_next;
    logic [RAD_W:0]   rem_reg  [SQ_W];
    logic [RAD_W:0]   rem_next [SQ_W];
    logic [SQ_W-1:0]  q_reg    [SQ_W];
    logic [SQ_W-1:0]  q_next   [SQ_W];
    sq_side_t         side_reg [SQ_W];
    sq_side_t         side_next[SQ_W];
    logic [RAD_W:0]   rem_src  [SQ_W];
    logic [SQ_W-1:0]  q_src    [SQ_W];
    logic [RAD_W:0]   trial    [SQ_W];

    // trial subtract: (q << (bit+1)) | (1 << 2*bit)
    always_comb
    begin
        for (int k = 0; k < SQ_W; k++)
        begin
            if (k == 0)
            begin
                rem_src[k]   = {1'b0, rad};
                q_src[k]     = '0;
                v_next[k]    = in_valid;
                side_next[k] = in_side;
            end
            else
            begin
                rem_src[k]   = rem_reg[k-1];
                q_src[k]     = q_reg[k-1];
                v_next[k]    = v_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            trial[k] = ((RAD_W+1)'(q_src[k]) << (SQ_W - k))
                     | ((RAD_W+1)'(1) << (2 * (SQ_W - 1 - k)));
            if (rem_src[k] >= trial[k])
            begin
                rem_next[k] = rem_src[k] - trial[k];
                q_next[k]   = q_src[k] | (SQ_W'(1) << (SQ_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_src[k];
                q_next[k]   = q_src[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_W; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            q_reg[k]    <= q_next[k];
            side_reg[k] <= side_next[k];
        end
    end

    assign out_valid = v_reg[SQ_W-1];
    assign root      = q_reg[SQ_W-1];
    assign exact     = (rem_reg[SQ_W-1] == '0);
    assign out_side  = side_reg[SQ_W-1];

endmodule

[src/qrs_div.sv]
module qrs_div
    import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [MAG_W-1:0] num_p,
    input  logic [MAG_W-1:0] num_m,
    input  logic [DEN_W-1:0] den,
    input  div_side_t        in_side,
    output logic             out_valid,
    output logic [MAG_W-1:0] quo_p,
    output logic [MAG_W-1:0] quo_m,
    output logic             rz_p,
    output logic             rz_m,
    output div_side_t        out_side
);

    // restoring division of two numerators by one denominator, one bit per stage;
    // np and nm hold remaining numerator bits on top and quotient bits below
    logic [MAG_W-1:0] v_reg;
    logic [MAG_W-1:0] v_next;
    logic [DEN_W-1:0] rp_reg   [MAG_W];
    logic [DEN_W-1:0] rp_next  [MAG_W];
    logic [DEN_W-1:0] rm_reg   [MAG_W];
    logic [DEN_W-1:0] rm_next  [MAG_W];
    logic [MAG_W-1:0] np_reg   [MAG_W];
    logic [MAG_W-1:0] np_next  [MAG_W];
    logic [MAG_W-1:0] nm_reg   [MAG_W];
    logic [MAG_W-1:0] nm_next  [MAG_W];
    logic [DEN_W-1:0] den_reg  [MAG_W];
    logic [DEN_W-1:0] den_next [MAG_W];
    div_side_t        side_reg [MAG_W];
    div_side_t        side_next[MAG_W];
    logic [DEN_W-1:0] rp_src   [MAG_W];
    logic [DEN_W-1:0] rm_src   [MAG_W];
    logic [MAG_W-1:0] np_src   [MAG_W];
    logic [MAG_W-1:0] nm_src   [MAG_W];
    logic [DEN_W:0]   tp       [MAG_W];
    logic [DEN_W:0]   tm       [MAG_W];

    always_comb
    begin
        for (int k = 0; k < MAG_W; k++)
        begin
            if (k == 0)
            begin
                rp_src[k]    = '0;
                rm_src[k]    = '0;
                np_src[k]    = num_p;
                nm_src[k]    = num_m;
                den_next[k]  = den;
                v_next[k]    = in_valid;
                side_next[k] = in_side;
            end
            else
            begin
                rp_src[k]    = rp_reg[k-1];
                rm_src[k]    = rm_reg[k-1];
                np_src[k]    = np_reg[k-1];
                nm_src[k]    = nm_reg[k-1];
                den_next[k]  = den_reg[k-1];
                v_next[k]    = v_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            tp[k] = {rp_src[k], np_src[k][MAG_W-1]};
            tm[k] = {rm_src[k], nm_src[k][MAG_W-1]};
            // plus numerator
            if (tp[k] >= {1'b0, den_next[k]})
            begin
                rp_next[k] = DEN_W'(tp[k] - {1'b0, den_next[k]});
                np_next[k] = {np_src[k][MAG_W-2:0], 1'b1};
            end
            else
            begin
                rp_next[k] = tp[k][DEN_W-1:0];
                np_next[k] = {np_src[k][MAG_W-2:0], 1'b0};
            end
            // minus numerator
            if (tm[k] >= {1'b0, den_next[k]})
            begin
                rm_next[k] = DEN_W'(tm[k] - {1'b0, den_next[k]});
                nm_next[k] = {nm_src[k][MAG_W-2:0], 1'b1};
            end
            else
            begin
                rm_next[k] = tm[k][DEN_W-1:0];
                nm_next[k] = {nm_src[k][MAG_W-2:0], 1'b0};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAG_W; k++)
        begin
            rp_reg[k]   <= rp_next[k];
            rm_reg[k]   <= rm_next[k];
            np_reg[k]   <= np_next[k];
            nm_reg[k]   <= nm_next[k];
            den_reg[k]  <= den_next[k];
            side_reg[k] <= side_next[k];
        end
    end

    assign out_valid = v_reg[MAG_W-1];
    assign quo_p     = np_reg[MAG_W-1];
    assign quo_m     = nm_reg[MAG_W-1];
    assign rz_p      = (rp_reg[MAG_W-1] == '0);
    assign rz_m      = (rm_reg[MAG_W-1] == '0);
    assign out_side  = side_reg[MAG_W-1];

endmodule

[src/quadratic_root_solver_top.sv]
// channel    | ports                   | handshake
// -----------+-------------------------+----------------------------------
// input      | start, busy, coefs      | taken when start high, busy low
// result     | done, result            | one-cycle strobe, no backpressure
//
// fully pipelined: one transaction per cycle, busy is never raised
// between the accepting edge and the edge that takes the result lie these
// registers: 2 discriminant stages, one stage per square root bit, a numerator
// stage, one stage per quotient bit and the output register
// reset clears all valid bits; transactions in flight are dropped
module quadratic_root_solver_top
    import qrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  coef_in_t  coefs,
    output logic      done,
    output root_out_t result
);

    logic                     v1_reg;
    logic signed [2*COEF_W-1:0] bb_reg, bb_next;
    logic signed [2*COEF_W-1:0] ac_reg, ac_next;
    logic signed [COEF_W-1:0]   a1_reg;
    logic signed [COEF_W-1:0]   b1_reg;

    logic                     v2_reg;
    logic [DISC_W-1:0]        dmag_reg, dmag_next;
    sq_side_t                 side2_reg, side2_next;

    logic signed [DSGN_W-1:0] d_full;
    logic                     a_neg;
    logic signed [COEF_W:0]   a_ext;
    logic signed [COEF_W:0]   a_abs;
    logic signed [COEF_W:0]   b_ext;

    logic                     sq_valid;
    logic [SQ_W-1:0]          sq_root;
    logic                     sq_exact;
    sq_side_t                 sq_side;

    logic                     v3_reg;
    logic [MAG_W-1:0]         nump_reg, nump_next;
    logic [MAG_W-1:0]         numm_reg, numm_next;
    logic [DEN_W-1:0]         den3_reg;
    div_side_t                side3_reg, side3_next;
    logic signed [NUM_W-1:0]  t_sh;
    logic signed [NUM_W-1:0]  r_ext;
    logic signed [NUM_W-1:0]  mp;
    logic signed [NUM_W-1:0]  mm;

    logic                     dv_valid;
    logic [MAG_W-1:0]         quo_p, quo_m;
    logic                     rz_p, rz_m;
    div_side_t                dv_side;

    logic signed [RES_W-1:0]  res_p, res_m;
    logic signed [ROOT_W-1:0] sat_p, sat_m;
    logic                     done_reg;
    root_out_t                result_reg, result_next;

    // never stalls
    assign busy = 1'b0;

    // stage 1: products b*b and a*c
    always_comb
    begin
        bb_next = $signed(coefs.coef_b) * $signed(coefs.coef_b);
        ac_next = $signed(coefs.coef_a) * $signed(coefs.coef_c);
    end

    // stage 2: discriminant, kind, numerator base and denominator
    always_comb
    begin
        d_full = DSGN_W'(bb_reg) - (DSGN_W'(ac_reg) <<< 2);
        a_neg  = a1_reg[COEF_W-1];
        a_ext  = (COEF_W+1)'(a1_reg);
        b_ext  = (COEF_W+1)'(b1_reg);
        a_abs  = a_neg ? -a_ext : a_ext;
        dmag_next = d_full[DSGN_W-1] ? '0 : d_full[DISC_W-1:0];
        side2_next.a_neg = a_neg;
        side2_next.t     = a_neg ? b_ext : -b_ext;
        side2_next.den   = {a_abs[COEF_W-1:0], 1'b0};
        priority if (a1_reg == '0)
        begin
            side2_next.kind = KIND_DEGEN;
        end
        else if (d_full[DSGN_W-1])
        begin
            side2_next.kind = KIND_COMPLEX;
        end
        else if (d_full == '0)
        begin
            side2_next.kind = KIND_REPEAT;
        end
        else
        begin
            side2_next.kind = KIND_TWO;
        end
    end

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .rad       (RAD_W'(dmag_reg) << (2 * FRAC_BITS)),
        .in_side   (side2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .exact     (sq_exact),
        .out_side  (sq_side)
    );

    // numerators t*2^F + r and t*2^F - r - (inexact), split into sign and magnitude
    always_comb
    begin
        t_sh  = NUM_W'(sq_side.t) <<< FRAC_BITS;
        r_ext = $signed({{(NUM_W - SQ_W){1'b0}}, sq_root});
        mp    = t_sh + r_ext;
        mm    = t_sh - r_ext - NUM_W'({1'b0, !sq_exact});
        nump_next = mp[NUM_W-1] ? MAG_W'(-mp) : MAG_W'(mp);
        numm_next = mm[NUM_W-1] ? MAG_W'(-mm) : MAG_W'(mm);
        side3_next.kind  = sq_side.kind;
        side3_next.a_neg = sq_side.a_neg;
        side3_next.neg_p = mp[NUM_W-1];
        side3_next.neg_m = mm[NUM_W-1];
        side3_next.exact = sq_exact;
    end

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num_p     (nump_reg),
        .num_m     (numm_reg),
        .den       (den3_reg),
        .in_side   (side3_reg),
        .out_valid (dv_valid),
        .quo_p     (quo_p),
        .quo_m     (quo_m),
        .rz_p      (rz_p),
        .rz_m      (rz_m),
        .out_side  (dv_side)
    );

    // truncate toward zero: a negative inexact value with zero remainder steps up by one
    always_comb
    begin
        res_p = dv_side.neg_p
              ? -RES_W'(quo_p) + RES_W'({1'b0, !dv_side.exact && rz_p})
              : RES_W'(quo_p);
        res_m = dv_side.neg_m
              ? -RES_W'(quo_m) + RES_W'({1'b0, !dv_side.exact && rz_m})
              : RES_W'(quo_m);
        sat_p = sat_root(CLAMP_W'(res_p));
        sat_m = sat_root(CLAMP_W'(res_m));
        result_next.root_kind = dv_side.kind;
        if (dv_side.kind == KIND_COMPLEX || dv_side.kind == KIND_DEGEN)
        begin
            result_next.root_plus  = '0;
            result_next.root_minus = '0;
        end
        else if (dv_side.a_neg)
        begin
            result_next.root_plus  = sat_m;
            result_next.root_minus = sat_p;
        end
        else
        begin
            result_next.root_plus  = sat_p;
            result_next.root_minus = sat_m;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= sq_valid;
            done_reg <= dv_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bb_reg     <= bb_next;
        ac_reg     <= ac_next;
        a1_reg     <= coefs.coef_a;
        b1_reg     <= coefs.coef_b;
        dmag_reg   <= dmag_next;
        side2_reg  <= side2_next;
        nump_reg   <= nump_next;
        numm_reg   <= numm_next;
        den3_reg   <= sq_side.den;
        side3_reg  <= side3_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/qrs_checker.sv]
module qrs_checker
    import qrs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input root_out_t result
);

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every accepted transaction gives a result after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after latency");

    // no result without an accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without transaction");

    // complex or degenerate results carry zero roots
    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.root_kind == KIND_COMPLEX || result.root_kind == KIND_DEGEN))
        |-> (result.root_plus == '0 && result.root_minus == '0))
        else $error("nonzero roots on complex or degenerate result");

    // a repeated root shows the same value twice
    a_repeat_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.root_kind == KIND_REPEAT) |-> (result.root_plus == result.root_minus))
        else $error("repeated root differs");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import qrs_pkg::*;

    localparam int IDLE_PCT    = 7;
    localparam int RAND_ITEMS  = 1250;
    localparam int STALL_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    coef_in_t  coefs;
    logic      done;
    root_out_t result;

    // expected roots, oldest first
    root_out_t roots_pending[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;

    // directed table; kind_known marks rows whose result is typed in
    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 kind_known;
        root_out_t          want;
    } coef_row_t;

    coef_row_t coef_table[$];

    quadratic_root_solver_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .coefs  (coefs),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor square root of a 128-bit value, with exactness flag
    function automatic logic [63:0] isqrt_floor(logic [127:0] n, output bit exact);
        logic [127:0] res;
        logic [127:0] bitv;
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            bitv = 128'd1 << (2 * i);
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
        end
        exact = (n == 0);
        return res[63:0];
    endfunction

    // truncated quotient of a value in [m, m+1), den > 0
    function automatic longint trunc_quot(longint m, bit exact, longint den);
        longint q;
        q = m / den;
        if (exact || m >= 0)
        begin
            return q;
        end
        if (m % den != 0)
        begin
            q = q - 1;
        end
        return q + 1;
    endfunction

    function automatic logic signed [ROOT_W-1:0] clamp_root(longint v);
        longint hi;
        hi = (longint'(1) <<< (ROOT_W - 1)) - 1;
        if (v > hi)
        begin
            v = hi;
        end
        if (v < -hi - 1)
        begin
            v = -hi - 1;
        end
        return v[ROOT_W-1:0];
    endfunction

    // compute the roots of one coefficient triple
    function automatic root_out_t solve_roots(coef_in_t cin);
        root_out_t    r;
        longint       a;
        longint       b;
        longint       c;
        logic [127:0] disc;
        logic [127:0] bsq;
        logic [127:0] ac4;
        logic [63:0]  sq;
        bit           exact;
        longint       den;
        longint       t;
        longint       mp;
        longint       mm;
        a = cin.coef_a;
        b = cin.coef_b;
        c = cin.coef_c;
        r.root_plus  = '0;
        r.root_minus = '0;
        if (a == 0)
        begin
            r.root_kind = KIND_DEGEN;
            return r;
        end
        bsq = 128'(b * b);
        ac4 = 128'((a < 0 ? -a : a) * (c < 0 ? -c : c)) << 2;
        if ((a < 0) != (c < 0) && c != 0)
        begin
            disc = bsq + ac4;
        end
        else if (bsq < ac4)
        begin
            r.root_kind = KIND_COMPLEX;
            return r;
        end
        else
        begin
            disc = bsq - ac4;
        end
        r.root_kind = (disc == 0) ? KIND_REPEAT : KIND_TWO;
        sq  = isqrt_floor(disc << (2 * FRAC_BITS), exact);
        den = 2 * (a < 0 ? -a : a);
        t   = (a < 0) ? b : -b;
        mp  = t * (longint'(1) <<< FRAC_BITS) + longint'(sq);
        mm  = t * (longint'(1) <<< FRAC_BITS) - longint'(sq) - (exact ? 0 : 1);
        if (a < 0)
        begin
            r.root_plus  = clamp_root(trunc_quot(mm, exact, den));
            r.root_minus = clamp_root(trunc_quot(mp, exact, den));
        end
        else
        begin
            r.root_plus  = clamp_root(trunc_quot(mp, exact, den));
            r.root_minus = clamp_root(trunc_quot(mm, exact, den));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // result checking
    always @(posedge clk)
    begin
        root_out_t exp_r;
        if (rst_n && done)
        begin
            if (roots_pending.size() == 0)
            begin
                report_mismatch("unexpected transaction", 64'(result), 64'd0);
            end
            else
            begin
                exp_r = roots_pending.pop_front();
                if (result.root_plus !== exp_r.root_plus)
                begin
                    report_mismatch("root_plus", 64'(result.root_plus), 64'(exp_r.root_plus));
                end
                if (result.root_minus !== exp_r.root_minus)
                begin
                    report_mismatch("root_minus", 64'(result.root_minus),
                                    64'(exp_r.root_minus));
                end
                if (result.root_kind !== exp_r.root_kind)
                begin
                    report_mismatch("root_kind", 64'(result.root_kind), 64'(exp_r.root_kind));
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog expired");
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 7)) - 16'sd3;
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return 16'($urandom_range(0, 511)) - 16'sd256;
            default: return 16'($urandom());
        endcase
    endfunction

    // one transaction; idles at random unless quiet
    task automatic send_coefs(coef_in_t cin, bit quiet, bit has_want, root_out_t want);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        coefs <= cin;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        roots_pending.push_back(has_want ? want : solve_roots(cin));
    endtask

    function automatic root_out_t known_root(root_kind_t k, longint rp, longint rm);
        root_out_t r;
        r.root_plus  = rp[ROOT_W-1:0];
        r.root_minus = rm[ROOT_W-1:0];
        r.root_kind  = k;
        return r;
    endfunction

    task automatic add_row(int a, int b, int c, bit known, root_out_t want);
        coef_row_t row;
        row.a = 16'(a);
        row.b = 16'(b);
        row.c = 16'(c);
        row.kind_known = known;
        row.want = want;
        coef_table.push_back(row);
    endtask

    // stimulus
    initial
    begin
        coef_in_t  cin;
        root_out_t none;
        int        quiet_lo;
        none = known_root(KIND_TWO, 0, 0);
        rst_n = 1'b0;
        start = 1'b0;
        coefs = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, complex, repeated, two roots, extremes
        add_row(0, 0, 0, 1, known_root(KIND_DEGEN, 0, 0));
        add_row(0, 32767, -32768, 1, known_root(KIND_DEGEN, 0, 0));
        add_row(1, 0, 1, 1, known_root(KIND_COMPLEX, 0, 0));
        add_row(32767, 0, 32767, 1, known_root(KIND_COMPLEX, 0, 0));
        add_row(-1, 0, -1, 1, known_root(KIND_COMPLEX, 0, 0));
        add_row(1, -2, 1, 1, known_root(KIND_REPEAT, 65536, 65536));
        add_row(1, 0, 0, 1, known_root(KIND_REPEAT, 0, 0));
        add_row(1, 0, -1, 1, known_root(KIND_TWO, 65536, -65536));
        add_row(-1, 0, 1, 1, known_root(KIND_TWO, -65536, 65536));
        add_row(1, -3, 2, 1, known_root(KIND_TWO, 131072, 65536));
        add_row(1, 0, -2, 0, none);
        add_row(-1, 1, 1, 0, none);
        add_row(3, 7, -5, 0, none);
        add_row(1, -32768, 0, 0, none);
        add_row(1, 32767, -32768, 0, none);
        add_row(-32768, -32768, 32767, 0, none);
        add_row(-32768, 32767, 32767, 0, none);
        add_row(32767, -32768, -32768, 0, none);
        add_row(-32768, 0, 0, 0, none);
        add_row(2, 4, 2, 0, none);
        add_row(-3, 5, -2, 0, none);
        add_row(1, 1, 0, 0, none);
        foreach (coef_table[i])
        begin
            cin.coef_a = coef_table[i].a;
            cin.coef_b = coef_table[i].b;
            cin.coef_c = coef_table[i].c;
            send_coefs(cin, 1'b0, coef_table[i].kind_known, coef_table[i].want);
        end

        // random part, with a stretch free of idling
        quiet_lo = $urandom_range(200, 600);
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            cin.coef_a = rand_coef();
            cin.coef_b = rand_coef();
            cin.coef_c = rand_coef();
            if ($urandom_range(0, 3) == 0)
            begin
                // repeated root: b even, c = b^2 / (4a) with small a
                cin.coef_a = 16'($urandom_range(1, 8));
                cin.coef_b = 16'(2 * cin.coef_a * ($urandom_range(0, 60) - 30));
                cin.coef_c = 16'((cin.coef_b * cin.coef_b) / (4 * cin.coef_a));
                if ($urandom_range(0, 1))
                begin
                    cin.coef_a = -cin.coef_a;
                    cin.coef_c = -cin.coef_c;
                end
            end
            send_coefs(cin, (n >= quiet_lo && n < quiet_lo + 300), 1'b0, none);
        end
        start <= 1'b0;

        while (roots_pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && roots_pending.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
